@@ src/lfsh_pkg.sv @@
// ============================================================================
// lfsh_pkg
// Shared types, codes and defaults of the length-filtered symbol histogram.
// ============================================================================
package lfsh_pkg;

    // default sizes of the bin store and the counters
    localparam int SYMBOL_COUNT_DEF  = 128;
    localparam int COUNTER_WIDTH_DEF = 48;

    // fixed field widths
    localparam int LEN_W     = 32;
    localparam int SYM_W     = 7;
    localparam int REQ_W     = 2;
    localparam int FIELD_W   = 48;
    localparam int CFG_IDX_W = 1;

    // request codes
    localparam logic [REQ_W-1:0] REQ_READ  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_BASE  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_QUERY = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_LEN = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN = 1'd1;

    typedef logic [FIELD_W-1:0] t_field;

    typedef struct packed {
        logic [REQ_W-1:0] req_type;
        logic [LEN_W-1:0] read_length;
        logic [SYM_W-1:0] symbol;
    } t_req;

    typedef struct packed {
        t_field symbol_count;
        t_field read_total;
        t_field base_total;
    } t_rsp;

endpackage

@@ src/lfsh_ifs.sv @@
// ============================================================================
// lfsh request and response channels
// Valid/ready channels carrying one request item or one result item.
// ============================================================================
interface lfsh_req_if;
    logic          valid;
    logic          ready;
    lfsh_pkg::t_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface lfsh_rsp_if;
    logic          valid;
    logic          ready;
    lfsh_pkg::t_rsp data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ src/lfsh_totals.sv @@
// ============================================================================
// lfsh_totals
// Length window registers, read filter flag and the two saturating totals.
// ============================================================================
module lfsh_totals #(
    parameter int COUNTER_WIDTH = lfsh_pkg::COUNTER_WIDTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [lfsh_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [lfsh_pkg::LEN_W-1:0]       i_cfg_data,
    input  logic                             i_start,
    input  logic [lfsh_pkg::LEN_W-1:0]       i_len,
    output logic                             o_in_range,
    output logic [COUNTER_WIDTH-1:0]         o_reads,
    output logic [COUNTER_WIDTH-1:0]         o_bases
);
    import lfsh_pkg::*;

    localparam int SUM_W = ((COUNTER_WIDTH > LEN_W) ? COUNTER_WIDTH : LEN_W) + 1;
    localparam logic [SUM_W-1:0] SUM_MAX = SUM_W'({COUNTER_WIDTH{1'b1}});

    logic [LEN_W-1:0]         r_min, n_min;
    logic [LEN_W-1:0]         r_max, n_max;
    logic                     r_in_range, n_in_range;
    logic [COUNTER_WIDTH-1:0] r_reads, n_reads;
    logic [COUNTER_WIDTH-1:0] r_bases, n_bases;
    logic                     w_fits;
    logic [SUM_W-1:0]         w_sum;

    // length window writes
    always_comb begin
        n_min = r_min;
        n_max = r_max;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MIN_LEN: n_min = i_cfg_data;
                CFG_MAX_LEN: n_max = i_cfg_data;
                default:     n_min = r_min;
            endcase
        end
    end

    // filter and saturating totals
    assign w_fits = (i_len >= r_min) && (i_len <= r_max);
    assign w_sum  = SUM_W'(r_bases) + SUM_W'(i_len);

    always_comb begin
        n_in_range = r_in_range;
        n_reads    = r_reads;
        n_bases    = r_bases;
        if (i_start) begin
            n_in_range = w_fits;
            if (w_fits) begin
                n_reads = (&r_reads) ? r_reads : r_reads + 1'b1;
                n_bases = (w_sum >= SUM_MAX) ? {COUNTER_WIDTH{1'b1}}
                                             : w_sum[COUNTER_WIDTH-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min      <= '0;
            r_max      <= '1;
            r_in_range <= 1'b0;
            r_reads    <= '0;
            r_bases    <= '0;
        end else begin
            r_min      <= n_min;
            r_max      <= n_max;
            r_in_range <= n_in_range;
            r_reads    <= n_reads;
            r_bases    <= n_bases;
        end
    end

    assign o_in_range = r_in_range;
    assign o_reads    = r_reads;
    assign o_bases    = r_bases;

endmodule

@@ src/lfsh_bins.sv @@
// ============================================================================
// lfsh_bins
// Histogram bin memory: registered read, saturating increment and write-back
// with forwarding of a write to a read of the same bin at the same edge.
// ============================================================================
module lfsh_bins #(
    parameter int SYMBOL_COUNT  = lfsh_pkg::SYMBOL_COUNT_DEF,
    parameter int COUNTER_WIDTH = lfsh_pkg::COUNTER_WIDTH_DEF,
    parameter int AW            = $clog2(SYMBOL_COUNT)
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_rd_en,
    input  logic [AW-1:0]            i_rd_addr,
    input  logic                     i_inc_en,
    input  logic [AW-1:0]            i_inc_addr,
    output logic [COUNTER_WIDTH-1:0] o_count
);
    import lfsh_pkg::*;

    logic [COUNTER_WIDTH-1:0] r_mem [SYMBOL_COUNT];
    logic [SYMBOL_COUNT-1:0]  r_vld;
    logic [COUNTER_WIDTH-1:0] r_rd_data;
    logic                     r_rd_vld;
    logic                     r_fwd_hit;
    logic [COUNTER_WIDTH-1:0] r_fwd_data;
    logic [COUNTER_WIDTH-1:0] w_cur;
    logic [COUNTER_WIDTH-1:0] w_inc;

    // current bin value: forwarded write, stored entry, or reset zero
    assign w_cur = r_fwd_hit ? r_fwd_data : (r_rd_vld ? r_rd_data : '0);
    assign w_inc = (&w_cur) ? w_cur : w_cur + 1'b1;

    // memory port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
        if (i_inc_en) begin
            r_mem[i_inc_addr] <= w_inc;
        end
    end

    // written flags and forwarding
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_rd_vld  <= 1'b0;
            r_fwd_hit <= 1'b0;
        end else begin
            if (i_inc_en) begin
                r_vld[i_inc_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_vld  <= r_vld[i_rd_addr];
                r_fwd_hit <= i_inc_en && (i_inc_addr == i_rd_addr);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_fwd_data <= w_inc;
        end
    end

    assign o_count = w_cur;

endmodule

@@ src/length_filtered_symbol_histogram_unit.sv @@
// ============================================================================
// length_filtered_symbol_histogram_unit
// Counts reads inside the length window, their summed lengths and per-character base counts.
//
//   channel   dir  payload                                   handshake
//   i_req     in   req_type, read_length, symbol             valid/ready
//   o_rsp     out  symbol_count, read_total, base_total      valid/ready
//   i_cfg_*   in   index 0 min length, index 1 max length    write enable
//
// One item per cycle while the input is not stalled. A query result passes
// through the stage register and then the output register; read start and base
// items give no result. The bin memory is read at accept and written in the
// following cycle, a same-bin write forwarded.
// Reset clears the per-bin written flags at once, no clearing pass.
// Input stalls only while a query waits behind a full output register.
// ============================================================================
module length_filtered_symbol_histogram_unit #(
    parameter int SYMBOL_COUNT  = lfsh_pkg::SYMBOL_COUNT_DEF,
    parameter int COUNTER_WIDTH = lfsh_pkg::COUNTER_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    lfsh_req_if.sink                       i_req,
    lfsh_rsp_if.source                     o_rsp,
    input  logic                           i_cfg_we,
    input  logic [lfsh_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [lfsh_pkg::LEN_W-1:0]     i_cfg_data
);
    import lfsh_pkg::*;

    localparam int AW = $clog2(SYMBOL_COUNT);

    logic                     w_accept;
    logic                     w_start;
    logic                     w_sym_ok;
    logic                     w_base_cnt;
    logic                     w_query;
    logic                     w_in_range;
    logic [COUNTER_WIDTH-1:0] w_reads;
    logic [COUNTER_WIDTH-1:0] w_bases;
    logic [COUNTER_WIDTH-1:0] w_count;
    logic [AW-1:0]            w_addr;
    logic                     w_out_free;
    logic                     w_s1_go;
    logic                     w_rd_en;
    logic                     w_inc_en;

    logic                     r_s1_vld, n_s1_vld;
    logic                     r_s1_query;
    logic                     r_s1_sym_ok;
    logic [AW-1:0]            r_s1_addr;
    logic [COUNTER_WIDTH-1:0] r_s1_reads;
    logic [COUNTER_WIDTH-1:0] r_s1_bases;
    logic                     r_out_vld, n_out_vld;
    t_rsp                     r_out;

    // item decode
    assign w_accept   = i_req.valid && i_req.ready;
    assign w_start    = w_accept && (i_req.data.req_type == REQ_READ);
    assign w_sym_ok   = int'(i_req.data.symbol) < SYMBOL_COUNT;
    assign w_base_cnt = (i_req.data.req_type == REQ_BASE) && w_in_range && w_sym_ok;
    assign w_query    = (i_req.data.req_type == REQ_QUERY);
    assign w_addr     = AW'(i_req.data.symbol);

    // stage control
    assign w_out_free  = !r_out_vld || o_rsp.ready;
    assign w_s1_go     = r_s1_vld && (!r_s1_query || w_out_free);
    assign i_req.ready = !r_s1_vld || w_s1_go;
    assign w_rd_en     = w_accept && w_sym_ok && (w_base_cnt || w_query);
    assign w_inc_en    = r_s1_vld && !r_s1_query;

    lfsh_totals #(
        .COUNTER_WIDTH (COUNTER_WIDTH)
    ) u_totals (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_start    (w_start),
        .i_len      (i_req.data.read_length),
        .o_in_range (w_in_range),
        .o_reads    (w_reads),
        .o_bases    (w_bases)
    );

    lfsh_bins #(
        .SYMBOL_COUNT  (SYMBOL_COUNT),
        .COUNTER_WIDTH (COUNTER_WIDTH),
        .AW            (AW)
    ) u_bins (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (w_rd_en),
        .i_rd_addr  (w_addr),
        .i_inc_en   (w_inc_en),
        .i_inc_addr (r_s1_addr),
        .o_count    (w_count)
    );

    // stage and output valid flags
    always_comb begin
        n_s1_vld = r_s1_vld;
        if (w_s1_go) begin
            n_s1_vld = 1'b0;
        end
        if (w_accept && (w_base_cnt || w_query)) begin
            n_s1_vld = 1'b1;
        end
    end

    always_comb begin
        n_out_vld = r_out_vld;
        if (o_rsp.ready) begin
            n_out_vld = 1'b0;
        end
        if (w_s1_go && r_s1_query) begin
            n_out_vld = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_s1_vld  <= n_s1_vld;
            r_out_vld <= n_out_vld;
        end
    end

    // stage payload, totals taken at accept
    always_ff @(posedge i_clk) begin
        if (w_accept && (w_base_cnt || w_query)) begin
            r_s1_query  <= w_query;
            r_s1_sym_ok <= w_sym_ok;
            r_s1_addr   <= w_addr;
            r_s1_reads  <= w_reads;
            r_s1_bases  <= w_bases;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (w_s1_go && r_s1_query) begin
            r_out.symbol_count <= r_s1_sym_ok ? t_field'(64'(w_count)) : '0;
            r_out.read_total   <= t_field'(64'(r_s1_reads));
            r_out.base_total   <= t_field'(64'(r_s1_bases));
        end
    end

    assign o_rsp.valid = r_out_vld;
    assign o_rsp.data  = r_out;

    // a query held behind a full output register blocks new items
    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld && r_s1_query && !w_out_free) |-> !i_req.ready)
        else $error("item taken while a query is stalled");

    // the read total never goes down
    a_reads_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> (w_reads >= $past(w_reads)))
        else $error("read total decreased");

    // only counted base items write the bin memory
    a_inc_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_inc_en |-> ($past(w_in_range) || $past(r_s1_vld)))
        else $error("bin written without an accepted read");

endmodule
